@@ hdl/gelu_pkg.sv @@
// Shared constants, control struct and table builders for the GELU activation unit.
// Depends on nothing; every other file of the unit imports it.
package gelu_pkg;

  localparam int FRAC_BITS = 12;
  localparam int ENTRY_W = 16;
  localparam int ROM_BITS = 10;
  localparam int ROM_LEN = (1 << ROM_BITS) + 1;
  localparam int U_BITS = 26;
  localparam int MC_BITS = 15;
  localparam int QUO_BITS = 48;

  localparam logic [MC_BITS-1:0] MC_LIMIT = 15'd16384;
  localparam logic [29:0] SQRT1_2_Q30 = 30'd759250125;
  localparam logic [29:0] SQRT_2_OVER_PI_Q30 = 30'd856722024;
  localparam logic [19:0] CUBIC_Q24 = 20'd750193;
  localparam logic [ENTRY_W-1:0] G_ONE = 16'd32768;

  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint EXP_M1_Q30 = 64'sd395007542;
  localparam longint TWO_OVER_SQRTPI_Q30 = 64'sd1211587905;
  localparam longint ENTRY_MAX = 64'sd32767;
  localparam longint SIMPSON_DIV = 64'sd1536;

  typedef logic [ROM_LEN*ENTRY_W-1:0] rom_image_t;

  typedef struct packed {
    logic valid;
    logic tanh;
    logic neg;
  } gelu_ctl_t;

  // Quotient of a nonnegative value below 2^48 by a positive divisor, by shift and subtract.
  function automatic longint div_floor(longint num, longint den);
    longint quo;
    longint rem;
    quo = 0;
    rem = 0;
    for (int b = QUO_BITS - 1; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
      quo = quo <<< 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'sd1;
      end
    end
    return quo;
  endfunction

  // e^(-y) in Q30 for y in Q30.
  function automatic longint exp_neg_q30(longint y);
    longint ip;
    longint fr;
    longint sum;
    longint term;
    ip = y >>> 30;
    fr = y & (ONE_Q30 - 64'sd1);
    sum = ONE_Q30;
    term = ONE_Q30;
    for (int n = 1; n <= 14; n++) begin
      term = div_floor((term * fr) >>> 30, longint'(n));
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    for (longint k = 0; k < ip && k < 64; k++) begin
      sum = (sum * EXP_M1_Q30 + (ONE_Q30 >>> 1)) >>> 30;
    end
    return sum;
  endfunction

  // e^(-t^2) in Q30 with t = j / 512.
  function automatic longint gauss_at(longint j);
    return exp_neg_q30((j * j) <<< 12);
  endfunction

  // Erf at the finest segmentation by Simpson integration, entries in Q1.15.
  function automatic rom_image_t build_erf_image();
    rom_image_t img;
    longint acc;
    longint g0;
    longint g1;
    longint g2;
    longint integ;
    longint q;
    img = '0;
    acc = 0;
    g0 = gauss_at(0);
    for (longint j = 0; j < 2048; j += 2) begin
      g1 = gauss_at(j + 1);
      g2 = gauss_at(j + 2);
      acc = acc + g0 + 4 * g1 + g2;
      integ = div_floor(acc + 768, SIMPSON_DIV);
      q = (integ * TWO_OVER_SQRTPI_Q30 + (64'sd1 <<< 44)) >>> 45;
      if (q > ENTRY_MAX) begin
        q = ENTRY_MAX;
      end
      img[ENTRY_W*int'((j + 2) >>> 1) +: ENTRY_W] = ENTRY_W'(q);
      g0 = g2;
    end
    return img;
  endfunction

  // Tanh at the finest segmentation, entries in Q1.15.
  function automatic rom_image_t build_tanh_image();
    rom_image_t img;
    longint r;
    longint den;
    longint t;
    img = '0;
    for (int i = 0; i < ROM_LEN; i++) begin
      r = exp_neg_q30(longint'(i) <<< (33 - ROM_BITS));
      den = ONE_Q30 + r;
      t = div_floor(((ONE_Q30 - r) <<< 15) + (den >>> 1), den);
      if (t > ENTRY_MAX) begin
        t = ENTRY_MAX;
      end
      img[ENTRY_W*i +: ENTRY_W] = ENTRY_W'(t);
    end
    return img;
  endfunction

endpackage

@@ hdl/gelu_arg.sv @@
// Argument pipeline of the GELU unit: |x| scaled for erf, or the cubic tanh argument.
// Six register stages; depends on gelu_pkg.
module gelu_arg
  import gelu_pkg::*;
#(
  parameter int DATA_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  gelu_ctl_t                   ctl_in,
  input  logic signed [DATA_BITS-1:0] x_in,
  output gelu_ctl_t                   ctl_out,
  output logic signed [DATA_BITS-1:0] x_out,
  output logic [U_BITS-1:0]           u_out,
  output logic                        u_big
);

  localparam int STAGES = 6;
  localparam int PE_BITS = DATA_BITS + 30;
  localparam int UE_BITS = DATA_BITS + 12;

  gelu_ctl_t                   ctl_pipe [STAGES];
  logic signed [DATA_BITS-1:0] x_pipe   [STAGES];

  logic [DATA_BITS-1:0] mag;
  logic [MC_BITS-1:0]   mc_clamp;
  logic [DATA_BITS-1:0] m1, m2, m3;
  logic [MC_BITS-1:0]   mc1, mc2, mc3, mc4;
  logic [29:0]          sq2;
  logic [42:0]          cube3;
  logic [41:0]          chi4;
  logic [40:0]          clo4;
  logic [PE_BITS-1:0]   pe4;
  logic [63:0]          cube_sum;
  logic [PE_BITS-1:0]   pe_round;
  logic [UE_BITS-1:0]   ue_full;
  logic [26:0]          inner5;
  logic [U_BITS-1:0]    ue5;
  logic                 bige5;
  logic [56:0]          ut_full;

  always_comb begin
    mag = x_in[DATA_BITS-1] ? DATA_BITS'(-x_in) : DATA_BITS'(x_in);
    mc_clamp = (32'(mag) > 32'(MC_LIMIT)) ? MC_LIMIT : MC_BITS'(mag);
    cube_sum = (64'(chi4) << 21) + 64'(clo4) + (64'd1 << 35);
    pe_round = pe4 + PE_BITS'(64'd1 << 17);
    ue_full = pe_round[PE_BITS-1:18];
    ut_full = 57'(inner5) * 57'(SQRT_2_OVER_PI_Q30) + (57'd1 << 29);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STAGES; k++) begin
        ctl_pipe[k] <= '0;
      end
    end else begin
      ctl_pipe[0] <= ctl_in;
      for (int k = 1; k < STAGES; k++) begin
        ctl_pipe[k] <= ctl_pipe[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    x_pipe[0] <= x_in;
    for (int k = 1; k < STAGES; k++) begin
      x_pipe[k] <= x_pipe[k-1];
    end
    m1 <= mag;
    mc1 <= mc_clamp;
    sq2 <= 30'(mc1) * 30'(mc1);
    m2 <= m1;
    mc2 <= mc1;
    cube3 <= 43'(sq2) * 43'(mc2);
    m3 <= m2;
    mc3 <= mc2;
    chi4 <= 42'(cube3[42:21]) * 42'(CUBIC_Q24);
    clo4 <= 41'(cube3[20:0]) * 41'(CUBIC_Q24);
    pe4 <= PE_BITS'(m3) * PE_BITS'(SQRT1_2_Q30);
    mc4 <= mc3;
    inner5 <= (27'(mc4) << FRAC_BITS) + 27'(cube_sum[63:36]);
    ue5 <= U_BITS'(ue_full);
    bige5 <= (64'(ue_full) >= (64'd1 << U_BITS));
    if (ctl_pipe[4].tanh) begin
      u_out <= ut_full[55:30];
      u_big <= ut_full[56];
    end else begin
      u_out <= ue5;
      u_big <= bige5;
    end
  end

  assign ctl_out = ctl_pipe[STAGES-1];
  assign x_out = x_pipe[STAGES-1];

endmodule

@@ hdl/gelu_interp.sv @@
// Table lookup with linear interpolation of erf or tanh, result in Q1.15.
// Three register stages; the table images come from gelu_pkg.
module gelu_interp
  import gelu_pkg::*;
#(
  parameter int DATA_BITS = 16,
  parameter int SEGMENT_BITS = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  gelu_ctl_t                   ctl_in,
  input  logic signed [DATA_BITS-1:0] x_in,
  input  logic [U_BITS-1:0]           u_in,
  input  logic                        big_in,
  output gelu_ctl_t                   ctl_out,
  output logic signed [DATA_BITS-1:0] x_out,
  output logic [ENTRY_W-1:0]          g_out
);

  localparam int STAGES = 3;
  localparam int SH = U_BITS - SEGMENT_BITS;
  localparam int STEP_SHIFT = ROM_BITS - SEGMENT_BITS;
  localparam int PROD_BITS = SH + ENTRY_W + 1;
  localparam int SUM_BITS = PROD_BITS + 1;
  localparam logic [SH:0] W_FULL = {1'b1, {SH{1'b0}}};
  localparam logic [SH:0] HALF_W = W_FULL >> 1;
  localparam rom_image_t ERF_IMAGE = build_erf_image();
  localparam rom_image_t TANH_IMAGE = build_tanh_image();

  gelu_ctl_t                   ctl_pipe [STAGES];
  logic signed [DATA_BITS-1:0] x_pipe   [STAGES];

  logic [SEGMENT_BITS-1:0] idx;
  logic [ROM_BITS:0]       lo_addr;
  logic [ROM_BITS:0]       hi_addr;
  logic [ENTRY_W-1:0]      lo1, hi1;
  logic [SH-1:0]           fr1;
  logic                    big1, big2;
  logic [PROD_BITS-1:0]    plo2, phi2;
  logic [SUM_BITS-1:0]     isum;

  always_comb begin
    idx = u_in[U_BITS-1:SH];
    lo_addr = (ROM_BITS+1)'(idx) << STEP_SHIFT;
    hi_addr = ((ROM_BITS+1)'(idx) + (ROM_BITS+1)'(1)) << STEP_SHIFT;
    isum = SUM_BITS'(plo2) + SUM_BITS'(phi2) + SUM_BITS'(HALF_W);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STAGES; k++) begin
        ctl_pipe[k] <= '0;
      end
    end else begin
      ctl_pipe[0] <= ctl_in;
      for (int k = 1; k < STAGES; k++) begin
        ctl_pipe[k] <= ctl_pipe[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    x_pipe[0] <= x_in;
    for (int k = 1; k < STAGES; k++) begin
      x_pipe[k] <= x_pipe[k-1];
    end
    if (ctl_in.tanh) begin
      lo1 <= TANH_IMAGE[ENTRY_W*lo_addr +: ENTRY_W];
      hi1 <= TANH_IMAGE[ENTRY_W*hi_addr +: ENTRY_W];
    end else begin
      lo1 <= ERF_IMAGE[ENTRY_W*lo_addr +: ENTRY_W];
      hi1 <= ERF_IMAGE[ENTRY_W*hi_addr +: ENTRY_W];
    end
    fr1 <= u_in[SH-1:0];
    big1 <= big_in;
    plo2 <= PROD_BITS'(lo1) * PROD_BITS'(W_FULL - (SH+1)'(fr1));
    phi2 <= PROD_BITS'(hi1) * PROD_BITS'(fr1);
    big2 <= big1;
    g_out <= big2 ? G_ONE : ENTRY_W'(isum >> SH);
  end

  assign ctl_out = ctl_pipe[STAGES-1];
  assign x_out = x_pipe[STAGES-1];

endmodule

@@ hdl/gelu_activation_unit.sv @@
// Top level of the GELU activation unit: command port, configuration, final scaling.
// Instantiates gelu_arg and gelu_interp; depends on gelu_pkg.
//
//   channel   handshake                 payload
//   command   start / busy              operand_a, operand_b
//   result    done (one-cycle strobe)   activation
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A new item is taken in every cycle while busy is low; the pipeline has 13 register
// stages, and done and activation are registered in its last stage for each accepted item.
// The depth is set by the tanh argument path (four multiplies and a rounding add).
// Reset is synchronous; busy is high and cfg_ready low from reset until the first
// clock edge at which rst is low. The pipeline never stalls, since results cannot be held off.
module gelu_activation_unit
  import gelu_pkg::*;
#(
  parameter int SEGMENT_BITS = 6,
  parameter int DATA_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [DATA_BITS-1:0] operand_a,
  input  logic signed [DATA_BITS-1:0] operand_b,
  output logic                        done,
  output logic signed [DATA_BITS-1:0] activation,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [31:0]                 cfg_data
);

  typedef enum logic [1:0] {
    REG_USE_TANH     = 2'd0,
    REG_ADD_OPERANDS = 2'd1
  } cfg_reg_t;

  localparam int PF_BITS = DATA_BITS + 18;
  localparam logic signed [DATA_BITS-1:0] X_MAX = {1'b0, {(DATA_BITS-1){1'b1}}};
  localparam logic signed [DATA_BITS-1:0] X_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};

  logic use_tanh_form;
  logic add_operands;
  logic accept;

  gelu_ctl_t                   ctl0, ctl1, ctl_a, ctl_i, ctl_f;
  logic                        add0;
  logic signed [DATA_BITS-1:0] a0, b0, x1, x_a, x_i;
  logic [DATA_BITS:0]          sum;
  logic signed [DATA_BITS-1:0] x_next;
  logic [U_BITS-1:0]           u_a;
  logic                        big_a;
  logic [ENTRY_W-1:0]          g_i;
  logic signed [17:0]          factor;
  logic signed [PF_BITS-1:0]   prodf;
  logic signed [PF_BITS-1:0]   rnd;
  logic signed [DATA_BITS+1:0] scaled;
  logic signed [DATA_BITS-1:0] activation_next;

  assign accept = start && !busy;
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      use_tanh_form <= 1'b0;
      add_operands <= 1'b0;
    end else begin
      busy <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_USE_TANH:     use_tanh_form <= cfg_data[0];
          REG_ADD_OPERANDS: add_operands <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    sum = {a0[DATA_BITS-1], a0} + {b0[DATA_BITS-1], b0};
    if (!add0) begin
      x_next = a0;
    end else if (sum[DATA_BITS] != sum[DATA_BITS-1]) begin
      x_next = sum[DATA_BITS] ? X_MIN : X_MAX;
    end else begin
      x_next = sum[DATA_BITS-1:0];
    end
    factor = ctl_i.neg ? (18'sd32768 - $signed(18'(g_i))) : (18'sd32768 + $signed(18'(g_i)));
    rnd = prodf + PF_BITS'(64'sd32768);
    scaled = $signed(rnd[PF_BITS-1:16]);
    if (scaled > (DATA_BITS+2)'(X_MAX)) begin
      activation_next = X_MAX;
    end else if (scaled < (DATA_BITS+2)'(X_MIN)) begin
      activation_next = X_MIN;
    end else begin
      activation_next = scaled[DATA_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl0 <= '0;
      ctl1 <= '0;
      ctl_f <= '0;
      done <= 1'b0;
    end else begin
      ctl0 <= '{valid: accept, tanh: use_tanh_form, neg: 1'b0};
      ctl1 <= '{valid: ctl0.valid, tanh: ctl0.tanh, neg: x_next[DATA_BITS-1]};
      ctl_f <= ctl_i;
      done <= ctl_f.valid;
    end
  end

  always_ff @(posedge clk) begin
    a0 <= operand_a;
    b0 <= operand_b;
    add0 <= add_operands;
    x1 <= x_next;
    prodf <= PF_BITS'(x_i) * PF_BITS'(factor);
    activation <= activation_next;
  end

  gelu_arg #(
    .DATA_BITS(DATA_BITS)
  ) u_arg (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (ctl1),
    .x_in   (x1),
    .ctl_out(ctl_a),
    .x_out  (x_a),
    .u_out  (u_a),
    .u_big  (big_a)
  );

  gelu_interp #(
    .DATA_BITS   (DATA_BITS),
    .SEGMENT_BITS(SEGMENT_BITS)
  ) u_interp (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (ctl_a),
    .x_in   (x_a),
    .u_in   (u_a),
    .big_in (big_a),
    .ctl_out(ctl_i),
    .x_out  (x_i),
    .g_out  (g_i)
  );

  // Every accepted command transaction yields exactly one strobe.
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##13 done)
    else $error("result strobe missing after an accepted transaction");

  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 13))
    else $error("result strobe without an accepted transaction");

  // The interpolated erf or tanh magnitude never exceeds one.
  a_g_in_range: assert property (@(posedge clk) disable iff (rst)
    ctl_i.valid |-> (g_i <= G_ONE))
    else $error("interpolated value above one");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for gelu_activation_unit: directed corners, then random operands.
// Holds its own fixed-point GELU predictor in a small scoreboard class; needs only the RTL.
module tb_top;

  localparam int DATA_W = 16;
  localparam int SEG_BITS = 6;
  localparam int TABLE_LEN = (1 << SEG_BITS) + 1;
  localparam int ITEMS_PER_SETTING = 42;

  localparam logic [1:0] REG_USE_TANH_FORM = 2'd0;
  localparam logic [1:0] REG_ADD_OPERANDS = 2'd1;
  localparam logic [1:0] REG_UNMAPPED_LO = 2'd2;
  localparam logic [1:0] REG_UNMAPPED_HI = 2'd3;

  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint EXP_MINUS_ONE_Q30 = 64'sd395007542;
  localparam longint TWO_OVER_SQRT_PI_Q30 = 64'sd1211587905;
  localparam longint HALF_SQRT2_Q30 = 64'sd759250125;
  localparam longint SQRT_TWO_OVER_PI_Q30 = 64'sd856722024;
  localparam longint CUBE_COEF_Q24 = 64'sd750193;
  localparam longint G_UNITY = 64'sd32768;
  localparam longint ENTRY_LIMIT = 64'sd32767;

  localparam logic signed [DATA_W-1:0] CORNER_A [6] = '{
    16'h0000, 16'h7FFF, 16'h8000, 16'h4000, 16'hA57E, 16'h0001
  };
  localparam logic signed [DATA_W-1:0] CORNER_B [6] = '{
    16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'hFFFE
  };

  class gelu_scoreboard;
    longint erf_points[TABLE_LEN];
    longint tanh_points[TABLE_LEN];
    bit use_tanh_form;
    bit add_operands;
    int failures;
    logic signed [DATA_W-1:0] expected_activations[$];

    function new();
      longint acc;
      longint integ;
      longint q;
      longint r;
      longint den;
      longint t;
      int stride;
      stride = 11 - SEG_BITS;
      use_tanh_form = 1'b0;
      add_operands = 1'b0;
      failures = 0;
      acc = 0;
      erf_points[0] = 0;
      for (longint j = 0; j < 2048; j += 2) begin
        acc += gauss(j) + 4 * gauss(j + 1) + gauss(j + 2);
        if (((j + 2) & ((64'sd1 <<< stride) - 1)) == 0) begin
          integ = (acc + 768) / 1536;
          q = (integ * TWO_OVER_SQRT_PI_Q30 + (64'sd1 <<< 44)) >>> 45;
          erf_points[int'((j + 2) >>> stride)] = (q > ENTRY_LIMIT) ? ENTRY_LIMIT : q;
        end
      end
      for (int i = 0; i < TABLE_LEN; i++) begin
        r = decay_q30(longint'(i) <<< (33 - SEG_BITS));
        den = Q30_ONE + r;
        t = (((Q30_ONE - r) <<< 15) + den / 2) / den;
        tanh_points[i] = (t > ENTRY_LIMIT) ? ENTRY_LIMIT : t;
      end
    endfunction

    function longint decay_q30(longint y);
      longint whole;
      longint frac;
      longint acc;
      longint term;
      whole = y >>> 30;
      frac = y & (Q30_ONE - 1);
      acc = Q30_ONE;
      term = Q30_ONE;
      for (int n = 1; n <= 14; n++) begin
        term = ((term * frac) >>> 30) / longint'(n);
        if (n % 2 == 1) begin
          acc -= term;
        end else begin
          acc += term;
        end
      end
      for (longint k = 0; k < whole && k < 64; k++) begin
        acc = (acc * EXP_MINUS_ONE_Q30 + (Q30_ONE >>> 1)) >>> 30;
      end
      return acc;
    endfunction

    function longint gauss(longint j);
      return decay_q30((j * j) <<< 12);
    endfunction

    function longint clamp_data(longint v);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (DATA_W - 1)) - 1;
      lo = -(64'sd1 <<< (DATA_W - 1));
      return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function longint interpolate(bit from_tanh, longint u);
      int sh;
      int idx;
      longint w;
      longint fr;
      longint lo_pt;
      longint hi_pt;
      sh = 26 - SEG_BITS;
      w = 64'sd1 <<< sh;
      if (u >= (64'sd4 <<< 24)) begin
        return G_UNITY;
      end
      idx = int'(u >>> sh);
      fr = u & (w - 1);
      lo_pt = from_tanh ? tanh_points[idx] : erf_points[idx];
      hi_pt = from_tanh ? tanh_points[idx + 1] : erf_points[idx + 1];
      return (lo_pt * (w - fr) + hi_pt * fr + w / 2) >>> sh;
    endfunction

    function logic signed [DATA_W-1:0] predict_activation(logic signed [DATA_W-1:0] a,
                                                         logic signed [DATA_W-1:0] b);
      longint x;
      longint m;
      longint mc;
      longint cube;
      longint inner;
      longint u;
      longint g;
      bit neg;
      x = longint'(a);
      if (add_operands) begin
        x = clamp_data(x + longint'(b));
      end
      neg = (x < 0);
      m = neg ? -x : x;
      if (use_tanh_form) begin
        mc = (m > (64'sd4 <<< 12)) ? (64'sd4 <<< 12) : m;
        cube = ((mc * mc * mc) * CUBE_COEF_Q24 + (64'sd1 <<< 35)) >>> 36;
        inner = (mc <<< 12) + cube;
        u = (inner * SQRT_TWO_OVER_PI_Q30 + (64'sd1 <<< 29)) >>> 30;
        g = interpolate(1'b1, u);
      end else begin
        u = (m * HALF_SQRT2_Q30 + (64'sd1 <<< 17)) >>> 18;
        g = interpolate(1'b0, u);
      end
      if (neg) begin
        g = -g;
      end
      return DATA_W'(clamp_data((x * (G_UNITY + g) + (64'sd1 <<< 15)) >>> 16));
    endfunction

    function void set_register(logic [1:0] index, logic [31:0] data);
      case (index)
        REG_USE_TANH_FORM: use_tanh_form = data[0];
        REG_ADD_OPERANDS: add_operands = data[0];
        default: ;
      endcase
    endfunction

    function void record_operands(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
      expected_activations.push_back(predict_activation(a, b));
    endfunction

    function void check_activation(logic signed [DATA_W-1:0] actual);
      logic signed [DATA_W-1:0] want;
      if (expected_activations.size() == 0) begin
        $display("%0t: unexpected result transaction, activation %0d", $time, actual);
        failures++;
      end else begin
        want = expected_activations.pop_front();
        if (actual !== want) begin
          $display("%0t: activation mismatch, expected %0d actual %0d", $time, want, actual);
          failures++;
        end
      end
    endfunction

    function int pending();
      return expected_activations.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [DATA_W-1:0] operand_a = '0;
  logic signed [DATA_W-1:0] operand_b = '0;
  logic done;
  logic signed [DATA_W-1:0] activation;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  gelu_scoreboard sb = new();

  always #1 clk = ~clk;

  gelu_activation_unit #(
    .SEGMENT_BITS(SEG_BITS),
    .DATA_BITS(DATA_W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .done(done),
    .activation(activation),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        sb.set_register(cfg_index, cfg_data);
      end
      if (start && !busy) begin
        sb.record_operands(operand_a, operand_b);
      end
      if (done) begin
        sb.check_activation(activation);
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_operand();
    int kind;
    int v;
    kind = $urandom_range(3);
    case (kind)
      0: v = $urandom();
      1: v = $urandom_range(32768) - 16384;
      2: begin
        v = ($urandom_range(1) ? 11900 : 23170) + $urandom_range(600) - 300;
        if ($urandom_range(1)) begin
          v = -v;
        end
      end
      default: v = $urandom_range(1) ? 32767 - $urandom_range(15) : -32768 + $urandom_range(15);
    endcase
    return DATA_W'(v);
  endfunction

  task automatic send_operands(input logic signed [DATA_W-1:0] a,
                               input logic signed [DATA_W-1:0] b, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_register(input logic [1:0] index, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic apply_setting(input bit tanh_form, input bit add_mode);
    logic [31:0] data;
    data = $urandom();
    write_register($urandom_range(1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI, data);
    data = $urandom();
    data[0] = tanh_form;
    write_register(REG_USE_TANH_FORM, data);
    data = $urandom();
    data[0] = add_mode;
    write_register(REG_ADD_OPERANDS, data);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int idle_pct;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int s = 0; s < 4; s++) begin
      drain_results();
      apply_setting(s[0], s[1]);
      for (int i = 0; i < 6; i++) begin
        send_operands(CORNER_A[i], CORNER_B[i], 0);
      end
    end
    for (int profile = 0; profile < 3; profile++) begin
      idle_pct = (profile == 0) ? 15 : ((profile == 1) ? 67 : 0);
      for (int s = 0; s < 4; s++) begin
        drain_results();
        apply_setting(s[0], s[1]);
        for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
          if (profile == 0 && i == ITEMS_PER_SETTING / 2) begin
            drain_results();
          end
          send_operands(pick_operand(), pick_operand(), idle_pct);
        end
      end
    end
    drain_results();
    repeat (20) @(negedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("gelu_activation_unit regression: pass");
    end else begin
      $display("gelu_activation_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("gelu_activation_unit regression: fail");
    $finish;
  end

endmodule
